// ----- hw/rtl/art_pkg.sv -----
// Shared types and constants of the acknowledgement and retransmission tracker.
package art_pkg;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned MAX_RESULTS = 8;

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned RES_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int unsigned RCNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [RCNT_W-1:0] RES_CAP  = RCNT_W'(MAX_RESULTS);

  localparam logic [15:0] RETRY_RST = 16'd600;
  localparam logic [3:0]  MAXT_RST  = 4'd6;

  typedef enum logic [1:0] {
    M_SEND  = 2'd0,
    M_ACK   = 2'd1,
    M_SWEEP = 2'd2,
    M_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    K_SENT      = 4'd0,
    K_RESEND    = 4'd1,
    K_GAVEUP    = 4'd2,
    K_ACKED     = 4'd3,
    K_UNMATCHED = 4'd4,
    K_NOLINK    = 4'd5,
    K_FULL      = 4'd6,
    K_CLEARED   = 4'd7,
    K_IDLE      = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    CFG_RETRY     = 2'd0,
    CFG_MAX_TRIES = 2'd1,
    CFG_TARGET    = 2'd2
  } cfg_idx_e;

  // one slot of the table memory
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] sent_at;
    logic [3:0]  tries;
  } slot_t;

  // one result beat, minus pending count and last flag
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  slot;
    logic [31:0] seq;
    logic [3:0]  tries;
  } result_t;

  // low three bits of a slot number
  function automatic logic [2:0] slot_field(logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] w;
    w = {3'b000, idx};
    return w[2:0];
  endfunction

  // low four bits of a pending count
  function automatic logic [3:0] pend_field(logic [CNT_W-1:0] cnt);
    logic [CNT_W+3:0] w;
    w = {4'b0000, cnt};
    return w[3:0];
  endfunction

endpackage

// ----- hw/rtl/ack_retransmit_tracker.sv -----
// Top level of the acknowledgement and retransmission tracker.
//
// Keeps up to SLOTS messages awaiting acknowledgement. Each input beat carries
// a mode in tuser: send (take the first free slot, tries 1, timestamp now_ms),
// ack (free the first used slot with a matching sequence number), sweep
// (resend or give up every due slot, at most eight per beat) or clear (empty
// the table). Send is refused unless link_up and target_set are both set.
// Every result beat carries the pending count after the whole input beat and
// tlast marks the final result of that beat. Slot number equals the address of
// the message payload in the external buffer. Send and clear write their single
// result into the result buffer on acceptance, and it then passes to the output
// register. Ack and sweep scan the slot memory one slot per cycle (one read
// port, registered read data, one compare or update per cycle), and an ack
// stops at its first hit. Results are then drained from a small result buffer
// at one beat per cycle while the output is not stalled. One beat is worked
// on at a time: each further sweep result and each output stall delays the
// next acceptance. The last result sits in the output register while the
// next beat is already taken. No clearing pass follows reset: slot occupancy
// is kept in flip-flops.
module ack_retransmit_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // seq_num[31:0], now_ms[63:32], link_up[64], zero
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // slot_index[2:0], out_seq[34:3], try_count[38:35],
                                      // pending_count[42:39], zero
  output logic [3:0]  m_axis_tuser,   // kind[3:0]
  output logic        m_axis_tlast    // last_of_run
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_e;

  // configuration
  logic [15:0] retry_q;
  logic [3:0]  maxt_q;
  logic        target_q;

  // control state
  state_e                       state_q, state_d;
  logic [art_pkg::SLOTS-1:0]    used_q, used_d;
  logic [art_pkg::CNT_W-1:0]    pend_q, pend_d;
  logic [art_pkg::IDX_W-1:0]    scan_q, scan_d;
  logic                         issue_q, issue_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [art_pkg::IDX_W-1:0]    rd_idx_q, rd_idx_d;
  logic [art_pkg::RCNT_W-1:0]   res_n_q, res_n_d;
  logic [art_pkg::RES_W-1:0]    emit_q, emit_d;
  logic                         m_valid_q, m_valid_d;

  // latched command
  art_pkg::mode_e cmd_mode_q;
  logic [31:0]    cmd_seq_q;
  logic [31:0]    cmd_now_q;

  // output register payload
  art_pkg::result_t m_res_q, m_res_d;
  logic [3:0]       m_pend_q, m_pend_d;
  logic             m_last_q, m_last_d;

  // slot memory
  art_pkg::slot_t              slot_mem [art_pkg::SLOTS];
  art_pkg::slot_t              rd_data_q;
  logic                        mem_we;
  logic [art_pkg::IDX_W-1:0]   mem_waddr;
  art_pkg::slot_t              mem_wdata;

  // result buffer
  art_pkg::result_t            res_buf [art_pkg::MAX_RESULTS];
  logic                        rb_we;
  logic [art_pkg::RES_W-1:0]   rb_widx;
  art_pkg::result_t            rb_wdata;

  // input fields
  art_pkg::mode_e in_mode;
  logic [31:0]    in_seq;
  logic [31:0]    in_now;
  logic           in_link;
  logic           accept;

  // first free slot
  logic                        free_found;
  logic [art_pkg::IDX_W-1:0]   free_idx;

  // scan datapath
  logic [31:0] age;
  logic        slot_live;
  logic        due;
  logic        last_slot;

  assign in_mode = art_pkg::mode_e'(s_axis_tuser);
  assign in_seq  = s_axis_tdata[31:0];
  assign in_now  = s_axis_tdata[63:32];
  assign in_link = s_axis_tdata[64];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = art_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = art_pkg::IDX_W'(i);
      end
    end
  end

  // age modulo 2^32 against the retry interval
  assign age       = cmd_now_q - rd_data_q.sent_at;
  assign slot_live = used_q[rd_idx_q];
  assign due       = slot_live && target_q && (age >= {16'h0000, retry_q});
  assign last_slot = (rd_idx_q == art_pkg::LAST_IDX);

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    pend_d    = pend_q;
    scan_d    = scan_q;
    issue_d   = issue_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    res_n_d   = res_n_q;
    emit_d    = emit_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_res_d   = m_res_q;
    m_pend_d  = m_pend_q;
    m_last_d  = m_last_q;

    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata.seq     = in_seq;
    mem_wdata.sent_at = in_now;
    mem_wdata.tries   = 4'd1;

    rb_we          = 1'b0;
    rb_widx        = res_n_q[art_pkg::RES_W-1:0];
    rb_wdata.kind  = art_pkg::K_IDLE;
    rb_wdata.slot  = 3'd0;
    rb_wdata.seq   = 32'd0;
    rb_wdata.tries = 4'd0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          emit_d  = '0;
          rb_widx = '0;
          unique case (in_mode)
            art_pkg::M_SEND: begin
              rb_we        = 1'b1;
              rb_wdata.seq = in_seq;
              res_n_d      = art_pkg::RCNT_W'(1);
              state_d      = S_EMIT;
              if (!in_link || !target_q) begin
                rb_wdata.kind = art_pkg::K_NOLINK;
              end else if (!free_found) begin
                rb_wdata.kind = art_pkg::K_FULL;
              end else begin
                mem_we           = 1'b1;
                used_d[free_idx] = 1'b1;
                pend_d           = pend_q + art_pkg::CNT_W'(1);
                rb_wdata.kind    = art_pkg::K_SENT;
                rb_wdata.slot    = art_pkg::slot_field(free_idx);
                rb_wdata.tries   = 4'd1;
              end
            end
            art_pkg::M_CLEAR: begin
              used_d        = '0;
              pend_d        = '0;
              rb_we         = 1'b1;
              rb_wdata.kind = art_pkg::K_CLEARED;
              res_n_d       = art_pkg::RCNT_W'(1);
              state_d       = S_EMIT;
            end
            default: begin
              // ack or sweep: walk the slot memory
              res_n_d = '0;
              scan_d  = '0;
              issue_d = 1'b1;
              state_d = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read issue, one slot a cycle
        if (issue_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q;
          if (scan_q == art_pkg::LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            scan_d = scan_q + art_pkg::IDX_W'(1);
          end
        end

        // evaluate the slot read last cycle
        if (rd_vld_q) begin
          if (cmd_mode_q == art_pkg::M_ACK) begin
            if (slot_live && (rd_data_q.seq == cmd_seq_q)) begin
              used_d[rd_idx_q] = 1'b0;
              pend_d           = pend_q - art_pkg::CNT_W'(1);
              rb_we            = 1'b1;
              rb_wdata.kind    = art_pkg::K_ACKED;
              rb_wdata.slot    = art_pkg::slot_field(rd_idx_q);
              rb_wdata.seq     = cmd_seq_q;
              rb_wdata.tries   = rd_data_q.tries;
              state_d          = S_EMIT;
            end else if (last_slot) begin
              rb_we         = 1'b1;
              rb_wdata.kind = art_pkg::K_UNMATCHED;
              rb_wdata.seq  = cmd_seq_q;
              state_d       = S_EMIT;
            end
          end else begin
            if (due) begin
              rb_we         = 1'b1;
              rb_wdata.slot = art_pkg::slot_field(rd_idx_q);
              rb_wdata.seq  = rd_data_q.seq;
              if (rd_data_q.tries >= maxt_q) begin
                used_d[rd_idx_q] = 1'b0;
                pend_d           = pend_q - art_pkg::CNT_W'(1);
                rb_wdata.kind    = art_pkg::K_GAVEUP;
                rb_wdata.tries   = rd_data_q.tries;
              end else begin
                mem_we            = 1'b1;
                mem_waddr         = rd_idx_q;
                mem_wdata.seq     = rd_data_q.seq;
                mem_wdata.sent_at = cmd_now_q;
                mem_wdata.tries   = rd_data_q.tries + 4'd1;
                rb_wdata.kind     = art_pkg::K_RESEND;
                rb_wdata.tries    = rd_data_q.tries + 4'd1;
              end
              if (res_n_q + art_pkg::RCNT_W'(1) == art_pkg::RES_CAP) begin
                state_d = S_EMIT;
              end
            end else if (last_slot && (res_n_q == '0)) begin
              rb_we = 1'b1;   // nothing was due
            end
            if (last_slot) begin
              state_d = S_EMIT;
            end
          end
          if (rb_we) begin
            res_n_d = res_n_q + art_pkg::RCNT_W'(1);
          end
        end

        if (state_d == S_EMIT) begin
          issue_d  = 1'b0;
          rd_vld_d = 1'b0;
        end
      end

      S_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_res_d   = res_buf[emit_q];
          m_pend_d  = art_pkg::pend_field(pend_q);
          m_last_d  = ({1'b0, emit_q} + art_pkg::RCNT_W'(1) == res_n_q);
          if (m_last_d) begin
            state_d = S_IDLE;
          end else begin
            emit_d = emit_q + art_pkg::RES_W'(1);
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      pend_q    <= '0;
      scan_q    <= '0;
      issue_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      res_n_q   <= '0;
      emit_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      pend_q    <= pend_d;
      scan_q    <= scan_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      rd_idx_q  <= rd_idx_d;
      res_n_q   <= res_n_d;
      emit_q    <= emit_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_mode_q <= in_mode;
      cmd_seq_q  <= in_seq;
      cmd_now_q  <= in_now;
    end
    m_res_q  <= m_res_d;
    m_pend_q <= m_pend_d;
    m_last_q <= m_last_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q  <= art_pkg::RETRY_RST;
      maxt_q   <= art_pkg::MAXT_RST;
      target_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (art_pkg::cfg_idx_e'(cfg_addr_i))
        art_pkg::CFG_RETRY:     retry_q  <= cfg_wdata_i;
        art_pkg::CFG_MAX_TRIES: maxt_q   <= cfg_wdata_i[3:0];
        art_pkg::CFG_TARGET:    target_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= slot_mem[scan_q];
  end

  // result buffer
  always_ff @(posedge clk_i) begin
    if (rb_we) begin
      res_buf[rb_widx] <= rb_wdata;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b00000, m_pend_q, m_res_q.tries, m_res_q.seq, m_res_q.slot};
  assign m_axis_tuser  = m_res_q.kind;
  assign m_axis_tlast  = m_last_q;

endmodule

// ----- hw/rtl/art_checker.sv -----
// Port-level checks of the tracker, bound to the top level.
module art_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // one command in flight: the input closes right after a beat is taken
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // clear leaves an empty table and is a single result
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == art_pkg::K_CLEARED) |->
      (m_axis_tdata[42:39] == 4'd0) && m_axis_tlast)
    else $error("clear result with nonzero pending count");

  // a fresh send has one try and ends its run
  a_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == art_pkg::K_SENT) |->
      (m_axis_tdata[38:35] == 4'd1) && (m_axis_tdata[42:39] != 4'd0) && m_axis_tlast)
    else $error("bad send result");

  // an idle sweep names no entry
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == art_pkg::K_IDLE) |->
      (m_axis_tdata[38:0] == 39'd0) && m_axis_tlast)
    else $error("idle sweep result carries entry data");

endmodule

bind ack_retransmit_tracker art_checker u_art_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
